// File: design/fct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum culling test package
// Shared constants, item mode codes and the stored plane type.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int COORD_BITS = 32;
    localparam int IN_BITS    = (COORD_BITS < 32) ? COORD_BITS : 32;

    // Port widths of the item fields.
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 3;
    localparam int VAL_W   = 32;

    // Q16.16 values: fraction bits, exact product and sum widths.
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DW_W      = VAL_W + 1;
    localparam int SUM_W     = PROD_W + 3;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POINT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPHERE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOX    = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] nx;
        logic signed [VAL_W-1:0] ny;
        logic signed [VAL_W-1:0] nz;
        logic signed [VAL_W-1:0] d;
    } t_plane;

    // Keeps the low IN_BITS bits of a field and sign-extends them.
    function automatic logic signed [VAL_W-1:0] sext_in(input logic [VAL_W-1:0] v);
        return VAL_W'($signed(v[IN_BITS-1:0]));
    endfunction

endpackage

// File: design/frustum_cull_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum culling test
// Holds six Q16.16 planes and tests points, spheres and boxes against them.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless stalled and presents the visible
// bit of a query from its output register; a plane load gives no result. The
// item passes an input register, a corner-select register, a product register
// and the output register. Three signed 32x32 multipliers per plane work in
// parallel in the product stage, so one item a cycle goes through unless
// stalled. A load changes the plane set for every query accepted after it,
// and queries already in flight see the planes as they were. Each stage holds
// its item only while the stage after it is full, so a waiting result holds
// back the input only once every stage behind it has filled.
module frustum_cull_test
    import fct_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [INDEX_W-1:0] i_plane_index,
    input  logic [VAL_W-1:0]   i_a_x,
    input  logic [VAL_W-1:0]   i_a_y,
    input  logic [VAL_W-1:0]   i_a_z,
    input  logic [VAL_W-1:0]   i_b_x,
    input  logic [VAL_W-1:0]   i_b_y,
    input  logic [VAL_W-1:0]   i_b_z,
    input  logic [VAL_W-1:0]   i_offset_or_radius,

    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_visible
);

    // Stage 1: registered input item.
    logic                    r1_valid;
    logic [MODE_W-1:0]       r1_mode;
    logic [INDEX_W-1:0]      r1_idx;
    logic signed [VAL_W-1:0] r1_ax, r1_ay, r1_az;
    logic signed [VAL_W-1:0] r1_bx, r1_by, r1_bz;
    logic signed [VAL_W-1:0] r1_w;

    // Stage 2: low and high coordinate per axis, plus the offset term.
    logic                    r2_valid;
    logic [MODE_W-1:0]       r2_mode;
    logic [INDEX_W-1:0]      r2_idx;
    logic signed [VAL_W-1:0] r2_lo_x, r2_lo_y, r2_lo_z;
    logic signed [VAL_W-1:0] r2_hi_x, r2_hi_y, r2_hi_z;
    logic signed [VAL_W-1:0] r2_extra;
    logic signed [VAL_W-1:0] n2_lo_x, n2_lo_y, n2_lo_z;
    logic signed [VAL_W-1:0] n2_hi_x, n2_hi_y, n2_hi_z;
    logic signed [VAL_W-1:0] n2_extra;

    // Stage 3: exact products and offset sum for every plane.
    logic                     r3_valid;
    logic signed [PROD_W-1:0] r3_prod [NUM_PLANES][3];
    logic signed [DW_W-1:0]   r3_dw   [NUM_PLANES];
    logic signed [PROD_W-1:0] n3_prod [NUM_PLANES][3];
    logic signed [DW_W-1:0]   n3_dw   [NUM_PLANES];

    // Output register.
    logic r_o_valid;
    logic r_visible;
    logic n_visible;

    // Plane store, cleared by reset.
    t_plane [NUM_PLANES-1:0] r_planes;

    logic signed [SUM_W-1:0] sum_p [NUM_PLANES];
    logic [NUM_PLANES-1:0]   behind;

    logic out_free;
    logic ready3;
    logic ready2;
    logic ready1;
    logic r2_is_load;
    logic in_accept;

    // Each stage may take a new item when it is empty or its item moves on.
    // A load leaves stage 2 at once, since it only writes the plane store.
    assign r2_is_load = (r2_mode == MODE_LOAD);
    assign out_free   = !r_o_valid || !i_stall;
    assign ready3     = !r3_valid || out_free;
    assign ready2     = !r2_valid || r2_is_load || ready3;
    assign ready1     = !r1_valid || ready2;
    assign o_stall    = !ready1;
    assign in_accept  = i_valid && ready1;

    assign o_valid   = r_o_valid;
    assign o_visible = r_visible;

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (ready1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r1_mode <= i_mode;
            r1_idx  <= i_plane_index;
            r1_ax   <= sext_in(i_a_x);
            r1_ay   <= sext_in(i_a_y);
            r1_az   <= sext_in(i_a_z);
            r1_bx   <= sext_in(i_b_x);
            r1_by   <= sext_in(i_b_y);
            r1_bz   <= sext_in(i_b_z);
            r1_w    <= sext_in(i_offset_or_radius);
        end
    end

    // A box has all corners behind a plane exactly when its corner farthest
    // along the normal is behind it, so only the per-axis extremes are kept.
    // Other items carry their single point in both the low and high slots.
    always_comb begin
        n2_lo_x  = r1_ax;
        n2_lo_y  = r1_ay;
        n2_lo_z  = r1_az;
        n2_hi_x  = r1_ax;
        n2_hi_y  = r1_ay;
        n2_hi_z  = r1_az;
        n2_extra = '0;
        case (r1_mode)
            MODE_LOAD, MODE_SPHERE: begin
                n2_extra = r1_w;
            end
            MODE_BOX: begin
                n2_lo_x = (r1_bx < r1_ax) ? r1_bx : r1_ax;
                n2_hi_x = (r1_bx < r1_ax) ? r1_ax : r1_bx;
                n2_lo_y = (r1_by < r1_ay) ? r1_by : r1_ay;
                n2_hi_y = (r1_by < r1_ay) ? r1_ay : r1_by;
                n2_lo_z = (r1_bz < r1_az) ? r1_bz : r1_az;
                n2_hi_z = (r1_bz < r1_az) ? r1_az : r1_bz;
            end
            default: begin
                n2_extra = '0;
            end
        endcase
    end

    // Stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (ready2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid && ready2) begin
            r2_mode  <= r1_mode;
            r2_idx   <= r1_idx;
            r2_lo_x  <= n2_lo_x;
            r2_lo_y  <= n2_lo_y;
            r2_lo_z  <= n2_lo_z;
            r2_hi_x  <= n2_hi_x;
            r2_hi_y  <= n2_hi_y;
            r2_hi_z  <= n2_hi_z;
            r2_extra <= n2_extra;
        end
    end

    // A load writes its plane as it leaves stage 2, the same place where
    // queries read the planes, so item order is kept. Indexes past the last
    // plane match no entry and are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (r2_valid && r2_is_load) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (r2_idx == INDEX_W'(p)) begin
                    r_planes[p].nx <= r2_lo_x;
                    r_planes[p].ny <= r2_lo_y;
                    r_planes[p].nz <= r2_lo_z;
                    r_planes[p].d  <= r2_extra;
                end
            end
        end
    end

    // A negative normal component picks the low coordinate, otherwise the
    // high one.
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            n3_prod[p][0] = PROD_W'(r_planes[p].nx)
                          * PROD_W'(r_planes[p].nx[VAL_W-1] ? r2_lo_x : r2_hi_x);
            n3_prod[p][1] = PROD_W'(r_planes[p].ny)
                          * PROD_W'(r_planes[p].ny[VAL_W-1] ? r2_lo_y : r2_hi_y);
            n3_prod[p][2] = PROD_W'(r_planes[p].nz)
                          * PROD_W'(r_planes[p].nz[VAL_W-1] ? r2_lo_z : r2_hi_z);
            n3_dw[p]      = DW_W'(r_planes[p].d) + DW_W'(r2_extra);
        end
    end

    // Stage 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (ready3) begin
            r3_valid <= r2_valid && !r2_is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && r2_valid && !r2_is_load) begin
            r3_prod <= n3_prod;
            r3_dw   <= n3_dw;
        end
    end

    // Exact signed distance in Q32.32; on or behind means at most zero.
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            sum_p[p] = SUM_W'(r3_prod[p][0]) + SUM_W'(r3_prod[p][1])
                     + SUM_W'(r3_prod[p][2]) + (SUM_W'(r3_dw[p]) <<< FRAC_BITS);
            behind[p] = sum_p[p][SUM_W-1] || (sum_p[p] == '0);
        end
        n_visible = ~|behind;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r3_valid) begin
            r_visible <= n_visible;
        end
    end

`ifndef ASSERT_OFF
    // The plane store changes only when a load leaves stage 2.
    a_planes_only_by_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r2_valid && r2_is_load) |=> $stable(r_planes))
        else $error("plane store changed without a load");

    // With the output register empty, nothing in the pipeline can hold back input.
    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_o_valid |-> !o_stall)
        else $error("input stalled while the output register is empty");

    // A finished query moves into an empty output register on the next edge.
    a_result_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && !r_o_valid) |=> r_o_valid)
        else $error("query result did not reach the output register");
`endif

endmodule
